// ----- hw/rtl/vpp_pkg.sv -----
package vpp_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int MAT_W          = 32;
  localparam int SIZE_W         = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_C01 = 3'd0,
    REG_R0_C23 = 3'd1,
    REG_R1_C01 = 3'd2,
    REG_R1_C23 = 3'd3,
    REG_R2_C01 = 3'd4,
    REG_R2_C23 = 3'd5,
    REG_IMG_W  = 3'd6,
    REG_IMG_H  = 3'd7
  } vpp_reg_t;

  // Control bits that ride along with a request through the divider.
  typedef struct packed {
    logic vld;
    logic zero;
    logic neg;
  } vpp_tag_t;

endpackage

// ----- hw/rtl/vpp_divider.sv -----
module vpp_divider #(
  parameter int QW = vpp_pkg::COORD_BITS_DEF,
  parameter int NW = 96,
  parameter int DW = 96
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [NW-1:0]      num,
  input  logic [DW-1:0]      den,
  input  vpp_pkg::vpp_tag_t  tag_in,
  output logic [QW-1:0]      quo,
  output logic               ovf,
  output vpp_pkg::vpp_tag_t  tag_out
);

  localparam int W = DW + QW;

  logic [W-1:0]      rem_r [0:QW];
  logic [DW-1:0]     den_r [0:QW];
  logic [QW-1:0]     quo_r [0:QW];
  logic              ovf_r [0:QW];
  vpp_pkg::vpp_tag_t tag_r [0:QW];

  // Entry stage: the quotient fits in QW bits unless num >= den * 2^QW.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= W'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= (W'(num) >= (W'(den) << QW));
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;
    logic [W-1:0] trial;
    logic         take;
    assign trial = W'(den_r[k]) << SH;
    assign take  = (rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else if (en) begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? (rem_r[k] - trial) : rem_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= {quo_r[k][QW-2:0], take};
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo     = quo_r[QW];
  assign ovf     = ovf_r[QW];
  assign tag_out = tag_r[QW];

endmodule

// ----- hw/rtl/vertex_pinhole_projection.sv -----
// Throughput: one vertex per cycle unless a held result waits on out_tready; the restoring
// divider produces one quotient bit per stage, so its depth sets the latency.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the matrix with
// 4096 x [I | 0] and the image size with 640 x 480.
module vertex_pinhole_projection #(
  parameter int COORD_BITS = vpp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input vertex stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: vertex_x, vertex_y, vertex_z, then zero fill.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: tex_u, tex_v, then zero fill.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      out_tdata,
  // Fields from bit 0: depth_zero.
  output logic                                   out_tuser,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vpp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vpp_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int F     = CB / 2;
  localparam int MW    = vpp_pkg::MAT_W;
  localparam int SW    = vpp_pkg::SIZE_W;
  localparam int PRODW = CB + MW;
  // Three products plus the offset term need a few bits of headroom.
  localparam int PW    = PRODW + 3;
  localparam int NW    = PW + F;
  localparam int DW    = PW + SW;
  localparam int OUT_W = ((2*CB+7)/8)*8;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted; software must write them
  // only while the pipeline is empty, which the block itself does not enforce.
  // ---------------------------------------------------------------------------
  logic [vpp_pkg::CFG_DATA_W-1:0] mat_r [0:5];
  logic [SW-1:0]                  img_w_r;
  logic [SW-1:0]                  img_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= 64'd4096;
      mat_r[1] <= 64'd0;
      mat_r[2] <= 64'd4096 << 32;
      mat_r[3] <= 64'd0;
      mat_r[4] <= 64'd0;
      mat_r[5] <= 64'd4096;
      img_w_r  <= SW'(640);
      img_h_r  <= SW'(480);
    end else if (cfg_valid) begin
      unique case (vpp_pkg::vpp_reg_t'(cfg_index))
        vpp_pkg::REG_R0_C01: mat_r[0] <= cfg_data;
        vpp_pkg::REG_R0_C23: mat_r[1] <= cfg_data;
        vpp_pkg::REG_R1_C01: mat_r[2] <= cfg_data;
        vpp_pkg::REG_R1_C23: mat_r[3] <= cfg_data;
        vpp_pkg::REG_R2_C01: mat_r[4] <= cfg_data;
        vpp_pkg::REG_R2_C23: mat_r[5] <= cfg_data;
        vpp_pkg::REG_IMG_W:  img_w_r  <= cfg_data[SW-1:0];
        vpp_pkg::REG_IMG_H:  img_h_r  <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // A zero image size is treated as one.
  logic [SW-1:0] size_u, size_v;
  assign size_u = (img_w_r == '0) ? SW'(1) : img_w_r;
  assign size_v = (img_h_r == '0) ? SW'(1) : img_h_r;

  // The whole pipeline advances together; the output register frees up when
  // its result is taken, so a new request can enter in the cycle that it is taken.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: nine matrix-by-coordinate products.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0]    coord [0:2];
  logic signed [PRODW-1:0] prod_r [0:2][0:2];
  logic signed [MW-1:0]    ofs_r  [0:2];
  logic                    v1_r;

  for (genvar j = 0; j < 3; j++) begin : g_coord
    assign coord[j] = in_tdata[j*CB +: CB];
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [MW-1:0] m0, m1, m2;
    assign m0 = mat_r[2*r][MW-1:0];
    assign m1 = mat_r[2*r][2*MW-1:MW];
    assign m2 = mat_r[2*r+1][MW-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[r][0] <= PRODW'(m0) * PRODW'(coord[0]);
        prod_r[r][1] <= PRODW'(m1) * PRODW'(coord[1]);
        prod_r[r][2] <= PRODW'(m2) * PRODW'(coord[2]);
        ofs_r[r]     <= mat_r[2*r+1][2*MW-1:MW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: row sums, with the fourth column scaled to the coordinate format.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p_r [0:2];
  logic                 v2_r;

  for (genvar r = 0; r < 3; r++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[r] <= PW'(prod_r[r][0]) + PW'(prod_r[r][1]) + PW'(prod_r[r][2])
                  + (PW'(ofs_r[r]) <<< F);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: magnitudes, signs and the scaled divisors.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] mag0, mag1, mag2;
  assign mag0 = p_r[0][PW-1] ? PW'(-p_r[0]) : PW'(p_r[0]);
  assign mag1 = p_r[1][PW-1] ? PW'(-p_r[1]) : PW'(p_r[1]);
  assign mag2 = p_r[2][PW-1] ? PW'(-p_r[2]) : PW'(p_r[2]);

  logic [NW-1:0] num_u_r, num_v_r;
  logic [DW-1:0] den_u_r, den_v_r;
  logic          neg_u_r, neg_v_r, zero_r;
  logic          v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_u_r <= NW'(mag0) << F;
      num_v_r <= NW'(mag1) << F;
      den_u_r <= DW'(mag2) * DW'(size_u);
      den_v_r <= DW'(mag2) * DW'(size_v);
      neg_u_r <= p_r[0][PW-1] ^ p_r[2][PW-1];
      neg_v_r <= p_r[1][PW-1] ^ p_r[2][PW-1];
      zero_r  <= (p_r[2] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: CB + 1 stages each. A zero divisor only occurs with the zero
  // flag set, and the output stage then discards the quotient.
  // ---------------------------------------------------------------------------
  vpp_pkg::vpp_tag_t tag_u_in, tag_v_in, tag_u, tag_v;
  logic [CB-1:0]     quo_u, quo_v;
  logic              ovf_u, ovf_v;

  assign tag_u_in = '{vld: v3_r, zero: zero_r, neg: neg_u_r};
  assign tag_v_in = '{vld: v3_r, zero: zero_r, neg: neg_v_r};

  vpp_divider #(.QW(CB), .NW(NW), .DW(DW)) u_div_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .num     (num_u_r),
    .den     (den_u_r),
    .tag_in  (tag_u_in),
    .quo     (quo_u),
    .ovf     (ovf_u),
    .tag_out (tag_u)
  );

  vpp_divider #(.QW(CB), .NW(NW), .DW(DW)) u_div_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .num     (num_v_r),
    .den     (den_v_r),
    .tag_in  (tag_v_in),
    .quo     (quo_v),
    .ovf     (ovf_v),
    .tag_out (tag_v)
  );

  // ---------------------------------------------------------------------------
  // Output stage: saturate to the signed coordinate range, apply sign; zero at depth 0.
  // ---------------------------------------------------------------------------
  localparam logic [CB-1:0] LIM_POS = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] LIM_NEG = {1'b1, {(CB-1){1'b0}}};

  logic [CB-1:0] sat_u, sat_v, res_u_nxt, res_v_nxt;
  logic [CB-1:0] lim_u, lim_v;

  always_comb begin
    lim_u = tag_u.neg ? LIM_NEG : LIM_POS;
    lim_v = tag_v.neg ? LIM_NEG : LIM_POS;
    sat_u = (ovf_u || quo_u > lim_u) ? lim_u : quo_u;
    sat_v = (ovf_v || quo_v > lim_v) ? lim_v : quo_v;
    res_u_nxt = tag_u.neg ? CB'(-sat_u) : sat_u;
    res_v_nxt = tag_v.neg ? CB'(-sat_v) : sat_v;
    if (tag_u.zero) begin
      res_u_nxt = '0;
      res_v_nxt = '0;
    end
  end

  logic [CB-1:0] res_u_r, res_v_r;
  logic          dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_u.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_u_r <= res_u_nxt;
      res_v_r <= res_v_nxt;
      dz_r    <= tag_u.zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({res_v_r, res_u_r});
  assign out_tuser  = dz_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> res_u_r == '0 && res_v_r == '0)
    else $error("zero depth result carries nonzero coordinates");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    tag_u.vld == tag_v.vld && tag_u.zero == tag_v.zero)
    else $error("divider lanes out of step");

endmodule

// ----- tb/vertex_pinhole_projection_checker.sv -----
module vertex_pinhole_projection_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic        dz;
  } tex_result_t;

  logic [63:0] proj_regs [0:7];
  tex_result_t tex_queue [$];

  // Signed 32-bit matrix entry from its packed register.
  function automatic logic signed [31:0] mat_entry(int row, int col);
    logic [63:0] r;
    r = proj_regs[row*2 + col/2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic signed [127:0] row_dot(int row, logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
    logic signed [127:0] acc;
    acc = 128'(mat_entry(row, 0)) * 128'(x) + 128'(mat_entry(row, 1)) * 128'(y)
        + 128'(mat_entry(row, 2)) * 128'(z);
    acc = acc + (128'(mat_entry(row, 3)) <<< 16);
    return acc;
  endfunction

  // Truncating, saturating divide of num by den*size into Q16.16.
  function automatic logic [31:0] norm_div(logic signed [127:0] num,
                                           logic signed [127:0] den, logic [13:0] size);
    logic [127:0] n, d, q, lim;
    logic neg;
    neg = num[127] != den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    if (size == 14'd0) size = 14'd1;
    q = (n << 16) / (d * size);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [127:0] p0, p1, p2;
    tex_result_t e;
    if (!rst_n) begin
      proj_regs[0] <= 64'd4096;
      proj_regs[1] <= 64'd0;
      proj_regs[2] <= 64'd4096 << 32;
      proj_regs[3] <= 64'd0;
      proj_regs[4] <= 64'd0;
      proj_regs[5] <= 64'd4096;
      proj_regs[6] <= 64'd640;
      proj_regs[7] <= 64'd480;
      tex_queue.delete();
      pending = 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        proj_regs[cfg_index] <= (cfg_index >= vpp_pkg::REG_IMG_W) ?
                                {50'd0, cfg_data[13:0]} : cfg_data;
      if (in_tvalid && in_tready) begin
        p0 = row_dot(0, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
        p1 = row_dot(1, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
        p2 = row_dot(2, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
        if (p2 == 0) e = '{32'd0, 32'd0, 1'b1};
        else e = '{norm_div(p0, p2, proj_regs[6][13:0]),
                   norm_div(p1, p2, proj_regs[7][13:0]), 1'b0};
        tex_queue.insert(tex_queue.size(), e);
      end
      if (out_tvalid && out_tready) begin
        if (tex_queue.size() == 0) begin
          report("unexpected result", out_tdata[31:0], 32'd0);
        end else begin
          e = tex_queue.pop_front();
          if (out_tdata[31:0] !== e.u) report("tex_u", out_tdata[31:0], e.u);
          if (out_tdata[63:32] !== e.v) report("tex_v", out_tdata[63:32], e.v);
          if (out_tuser !== e.dz) report("depth_zero", 32'(out_tuser), 32'(e.dz));
        end
      end
      pending = tex_queue.size();
    end
  end
endmodule

// ----- tb/vertex_pinhole_projection_tb.sv -----
module vertex_pinhole_projection_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // Fields from bit 0: vertex_x, vertex_y, vertex_z.
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // Fields from bit 0: tex_u, tex_v.
  logic [63:0] out_tdata;
  // Fields from bit 0: depth_zero.
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  // While set, the receiver holds off so that the pipeline fills and stalls the input.
  bit          hold_off = 1'b0;

  always #4 clk = ~clk;

  vertex_pinhole_projection dut (.*);

  vertex_pinhole_projection_checker chk (.*);

  // Gap length: mostly zero or short, now and then a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver side: random back pressure, plus one long hold-off on request.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // Drives one request and waits for it to be accepted. Without a gap the
  // valid stays high so the next request follows back to back.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int g;
    in_tdata <= {z, y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Register writes happen only once the pipeline has drained.
  task automatic write_reg(vpp_pkg::vpp_reg_t idx, logic [63:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 2048)) - 1024) <<< 16;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'(signed'($urandom_range(0, 8192)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_matrix();
    for (int i = 0; i < 6; i++)
      write_reg(vpp_pkg::vpp_reg_t'(i), {rand_entry(), rand_entry()});
    write_reg(vpp_pkg::REG_IMG_W,
              $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(1, 8192)));
    write_reg(vpp_pkg::REG_IMG_H,
              $urandom_range(0, 3) == 0 ? 64'($urandom) : 64'($urandom_range(1, 16383)));
  endtask

  initial begin
    logic [31:0] ext [0:4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the scaled identity reset matrix: zero depth, extremes,
    // saturation and truncation of negative quotients.
    for (int i = 0; i < 5; i++) send_vertex(ext[i], ext[4 - i], ext[(i + 2) % 5]);
    send_vertex(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0001);
    send_vertex(32'hFFFF_FFFD, 32'h0000_0007, 32'hFFFF_FFFE);
    drain();
    // Zero image size counts as one; full-range matrix entries.
    write_reg(vpp_pkg::REG_IMG_W, 64'd0);
    write_reg(vpp_pkg::REG_IMG_H, 64'd8192);
    write_reg(vpp_pkg::REG_R0_C01, 64'h7FFF_FFFF_8000_0000);
    write_reg(vpp_pkg::REG_R0_C23, 64'h8000_0000_7FFF_FFFF);
    write_reg(vpp_pkg::REG_R1_C01, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(vpp_pkg::REG_R1_C23, 64'h0000_1000_0000_0000);
    write_reg(vpp_pkg::REG_R2_C01, 64'h0000_0000_0000_0000);
    write_reg(vpp_pkg::REG_R2_C23, 64'hFFFF_F000_0000_1000);
    for (int i = 0; i < 5; i++) send_vertex(ext[i], ext[(i + 1) % 5], ext[i]);
    send_vertex(32'd0, 32'd0, 32'h0001_0000); // depth exactly zero
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0002_0000);
    drain();

    // Random part in phases with fresh settings.
    for (int ph = 0; ph < 13; ph++) begin
      random_matrix();
      for (int n = 0; n < 150; n++) begin
        if (ph == 3 && n == 10) hold_off = 1'b1;
        send_vertex(rand_coord(), rand_coord(), rand_coord());
      end
      if (ph == 6) begin
        in_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        send_vertex($urandom, $urandom, $urandom);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("vertex_pinhole_projection_tb: clean");
    end else begin
      $display("vertex_pinhole_projection_tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("vertex_pinhole_projection_tb: errors");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/vpp_pkg.sv
hw/rtl/vpp_divider.sv
hw/rtl/vertex_pinhole_projection.sv
tb/vertex_pinhole_projection_checker.sv
tb/vertex_pinhole_projection_tb.sv
